// File: rtl/lpr_pkg.sv
// lpr_pkg: shared types and constants for the lru page replacement block
// field positions of the stream words, default sizes and the sequencer states
// no dependencies
package lpr_pkg;

  localparam int FRAMES_DEF     = 16;
  localparam int PAGE_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  // configuration register
  localparam int          CFG_W       = 5;
  localparam int          CFG_TDATA_W = 8;
  localparam logic [4:0]  CFG_RESET   = 5'd3;

  // input word
  localparam int IN_PAGE_W  = 8;
  localparam int IN_TDATA_W = 8;

  // result word, lowest bit first
  localparam int OUT_HIT_LSB    = 0;
  localparam int OUT_SLOT_LSB   = 1;
  localparam int OUT_SLOT_W     = 4;
  localparam int OUT_EVV_LSB    = 5;
  localparam int OUT_EVP_LSB    = 6;
  localparam int OUT_EVP_W      = 8;
  localparam int OUT_HTOT_LSB   = 14;
  localparam int OUT_TOT_W      = 16;
  localparam int OUT_FTOT_LSB   = 30;
  localparam int OUT_USED_W     = 46;
  localparam int OUT_TDATA_W    = 48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lpr_state_t;

endpackage

// File: rtl/lru_page_replacement_top.sv
// lru_page_replacement_top: least recently used page frame manager
// one request at a time: in_tready is high only in idle, so a new request waits until the
//   result of the last one is registered; the single compare stage walks the n active
//   frames one a cycle through the page memory read port
// reset: rst_n synchronous, active low; clears valid bits, ranks, fill pointer and
//   totals, sets frames_in_use to 3; no clearing pass
module lru_page_replacement_top #(
  parameter int FRAMES     = lpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lpr_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // page_number[7:0]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lpr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // hit[0], frame_slot[4:1], evicted_valid[5], evicted_page[13:6],
  // hit_total[29:14], fault_total[45:30], zero pad[47:46]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lpr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // frames_in_use[4:0], unused[7:5]
  input  logic                             cfg_tvalid,
  output logic                             cfg_tready,
  input  logic [lpr_pkg::CFG_TDATA_W-1:0]  cfg_tdata
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int RANK_W = IDX_W;
  localparam logic [RANK_W-1:0]     RANK_MAX  = RANK_W'(FRAMES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  lpr_pkg::lpr_state_t state_r, state_nxt;

  logic [lpr_pkg::CFG_W-1:0] frames_cfg_r;
  logic                      frame_valid_r [FRAMES];
  logic                      frame_valid_nxt [FRAMES];
  logic [RANK_W-1:0]         rank_r [FRAMES];
  logic [RANK_W-1:0]         rank_nxt [FRAMES];
  logic [CNT_W-1:0]          fill_ptr_r, fill_ptr_nxt;
  logic [COUNT_BITS-1:0]     hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_BITS-1:0]     fault_cnt_r, fault_cnt_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;

  logic [PAGE_BITS-1:0]         page_r, page_nxt;
  logic [CNT_W-1:0]             n_r, n_nxt;
  logic [CNT_W-1:0]             rd_cnt_r, rd_cnt_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                         found_r, found_nxt;
  logic [IDX_W-1:0]             match_slot_r, match_slot_nxt;
  logic [RANK_W-1:0]            match_rank_r, match_rank_nxt;
  logic [IDX_W-1:0]             vic_slot_r, vic_slot_nxt;
  logic [PAGE_BITS-1:0]         vic_page_r, vic_page_nxt;
  logic [RANK_W-1:0]            best_r, best_nxt;
  logic [lpr_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // page memory, one read and one write port
  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [PAGE_BITS-1:0] page_q_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;

  logic [CNT_W-1:0]  n_active;
  logic              cmp_valid_bit;
  logic [RANK_W-1:0] cmp_rank;
  logic              is_fill;
  logic [IDX_W-1:0]  upd_slot;
  logic [RANK_W-1:0] limit;
  logic              evict;
  logic [PAGE_BITS-1:0] ev_page;

  assign in_tready  = (state_r == lpr_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_tready = 1'b1;

  always_comb begin
    if (frames_cfg_r == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frames_cfg_r) > 32'(FRAMES)) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(frames_cfg_r);
    end
  end

  assign cmp_valid_bit = frame_valid_r[cmp_idx_r];
  assign cmp_rank      = rank_r[cmp_idx_r];

  // replacement decision from the finished scan
  assign is_fill  = !found_r && (fill_ptr_r < n_r);
  assign evict    = !found_r && !is_fill;
  assign upd_slot = found_r ? match_slot_r :
                    (is_fill ? fill_ptr_r[IDX_W-1:0] : vic_slot_r);
  assign limit    = found_r ? match_rank_r : best_r;
  assign ev_page  = evict ? vic_page_r : '0;

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    n_nxt          = n_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    match_slot_nxt = match_slot_r;
    match_rank_nxt = match_rank_r;
    vic_slot_nxt   = vic_slot_r;
    vic_page_nxt   = vic_page_r;
    best_nxt       = best_r;
    fill_ptr_nxt   = fill_ptr_r;
    hit_cnt_nxt    = hit_cnt_r;
    fault_cnt_nxt  = fault_cnt_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r;
    mem_we         = 1'b0;
    mem_waddr      = upd_slot;
    for (int i = 0; i < FRAMES; i++) begin
      frame_valid_nxt[i] = frame_valid_r[i];
      rank_nxt[i]        = rank_r[i];
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          page_nxt     = PAGE_BITS'(in_tdata);
          n_nxt        = n_active;
          rd_cnt_nxt   = '0;
          cmp_vld_nxt  = 1'b0;
          found_nxt    = 1'b0;
          vic_slot_nxt = '0;
          best_nxt     = '0;
          state_nxt    = lpr_pkg::ST_SCAN;
        end
      end
      lpr_pkg::ST_SCAN: begin
        // read stage: one frame address a cycle
        if (rd_cnt_r < n_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        // compare stage: first match and oldest frame
        if (cmp_vld_r) begin
          if (cmp_valid_bit && (page_q_r == page_r) && !found_r) begin
            found_nxt      = 1'b1;
            match_slot_nxt = cmp_idx_r;
            match_rank_nxt = cmp_rank;
          end
          if (cmp_idx_r == '0) begin
            vic_slot_nxt = '0;
            vic_page_nxt = page_q_r;
            best_nxt     = cmp_valid_bit ? cmp_rank : '0;
          end else if (cmp_valid_bit && (cmp_rank > best_r)) begin
            vic_slot_nxt = cmp_idx_r;
            vic_page_nxt = page_q_r;
            best_nxt     = cmp_rank;
          end
        end
        if ((rd_cnt_r == n_r) && !cmp_vld_r) begin
          state_nxt = lpr_pkg::ST_UPDATE;
        end
      end
      lpr_pkg::ST_UPDATE: begin
        if (!out_tvalid_r || out_tready) begin
          // age the frames younger than the touched one, or every valid frame on a fill
          for (int i = 0; i < FRAMES; i++) begin
            if ((CNT_W'(i) < n_r) && (IDX_W'(i) != upd_slot) && frame_valid_r[i] &&
                (is_fill || (rank_r[i] < limit)) && (rank_r[i] < RANK_MAX)) begin
              rank_nxt[i] = rank_r[i] + RANK_W'(1);
            end
          end
          rank_nxt[upd_slot]        = '0;
          frame_valid_nxt[upd_slot] = 1'b1;
          if (found_r) begin
            if (hit_cnt_r != COUNT_MAX) begin
              hit_cnt_nxt = hit_cnt_r + COUNT_BITS'(1);
            end
          end else begin
            mem_we = 1'b1;
            if (is_fill) begin
              fill_ptr_nxt = fill_ptr_r + CNT_W'(1);
            end
            if (fault_cnt_r != COUNT_MAX) begin
              fault_cnt_nxt = fault_cnt_r + COUNT_BITS'(1);
            end
          end
          out_tdata_nxt = '0;
          out_tdata_nxt[lpr_pkg::OUT_HIT_LSB] = found_r;
          out_tdata_nxt[lpr_pkg::OUT_SLOT_LSB +: lpr_pkg::OUT_SLOT_W] =
            lpr_pkg::OUT_SLOT_W'(upd_slot);
          out_tdata_nxt[lpr_pkg::OUT_EVV_LSB] = evict;
          out_tdata_nxt[lpr_pkg::OUT_EVP_LSB +: lpr_pkg::OUT_EVP_W] =
            lpr_pkg::OUT_EVP_W'(ev_page);
          out_tdata_nxt[lpr_pkg::OUT_HTOT_LSB +: lpr_pkg::OUT_TOT_W] =
            lpr_pkg::OUT_TOT_W'(hit_cnt_nxt);
          out_tdata_nxt[lpr_pkg::OUT_FTOT_LSB +: lpr_pkg::OUT_TOT_W] =
            lpr_pkg::OUT_TOT_W'(fault_cnt_nxt);
          out_tvalid_nxt = 1'b1;
          state_nxt      = lpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= lpr_pkg::CFG_RESET;
      fill_ptr_r   <= '0;
      hit_cnt_r    <= '0;
      fault_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_valid_r[i] <= 1'b0;
        rank_r[i]        <= '0;
      end
    end else begin
      if (cfg_tvalid) begin
        frames_cfg_r <= cfg_tdata[lpr_pkg::CFG_W-1:0];
      end
      fill_ptr_r   <= fill_ptr_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      fault_cnt_r  <= fault_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        frame_valid_r[i] <= frame_valid_nxt[i];
        rank_r[i]        <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    n_r          <= n_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    match_slot_r <= match_slot_nxt;
    match_rank_r <= match_rank_nxt;
    vic_slot_r   <= vic_slot_nxt;
    vic_page_r   <= vic_page_nxt;
    best_r       <= best_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_waddr] <= page_r;
    end
    page_q_r <= page_mem[rd_cnt_r[IDX_W-1:0]];
  end

endmodule

// File: rtl/lpr_checker.sv
// lpr_checker: port level checks for lru_page_replacement_top
// depends on lpr_pkg for the result word layout; bound to the top level below
module lpr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lpr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic out_hit, out_evv;
  logic [lpr_pkg::OUT_EVP_W-1:0] out_evp;

  assign out_hit = out_tdata[lpr_pkg::OUT_HIT_LSB];
  assign out_evv = out_tdata[lpr_pkg::OUT_EVV_LSB];
  assign out_evp = out_tdata[lpr_pkg::OUT_EVP_LSB +: lpr_pkg::OUT_EVP_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a request keeps the block busy for the scan
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while scanning");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_hit && out_evv))
    else $error("hit with eviction");

  a_evp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_evv |-> out_evp == '0)
    else $error("evicted page without eviction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind lru_page_replacement_top lpr_checker u_lpr_checker (.*);
